[src/ctc_greedy_decoder_unit_defines.svh]
// Assertion helpers used by the checker file.
`ifndef CTC_GREEDY_DECODER_UNIT_DEFINES_SVH
`define CTC_GREEDY_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTCGD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTCGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ctcgd_pkg.sv]
`default_nettype none

package ctcgd_pkg;

  localparam int unsigned ProbW     = 16;
  localparam int unsigned CharW     = 13;
  localparam int unsigned SumW      = 23;
  localparam int unsigned CntW      = 8;
  localparam int unsigned DividendW = SumW + 1;
  localparam int unsigned DivCntW   = $clog2(DividendW);

  localparam logic [SumW-1:0] SumMax     = {SumW{1'b1}};
  localparam logic [CntW-1:0] CountHwMax = {CntW{1'b1}};

  typedef struct packed {
    logic [ProbW-1:0] prob;
    logic             last_in_step;
    logic             last_in_sequence;
  } in_item_t;

  typedef struct packed {
    logic             has_char;
    logic [CharW-1:0] char_index;
    logic             end_of_sequence;
    logic [ProbW-1:0] mean_score;
    logic             empty_sequence;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [CntW-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProbW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[src/ctcgd_divider.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient saturates to
// the probability width.
module ctcgd_divider
  import ctcgd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DividendW - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [DivCntW-1:0]   step_q;
  logic [CntW-1:0]      rem_q;
  logic [CntW-1:0]      dsr_q;
  logic [DividendW-1:0] quo_q;
  logic [CntW:0]        shifted;
  logic [CntW:0]        trial;
  logic                 fits;

  assign shifted = {rem_q, quo_q[DividendW-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rem_q  <= '0;
        dsr_q  <= req_i.divisor;
        quo_q  <= req_i.dividend;
      end else if (busy_q) begin
        rem_q  <= fits ? trial[CntW-1:0] : shifted[CntW-1:0];
        quo_q  <= {quo_q[DividendW-2:0], fits};
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = (quo_q[DividendW-1:ProbW] != '0) ? {ProbW{1'b1}}
                                                           : quo_q[ProbW-1:0];

endmodule

`default_nettype wire

[src/ctc_greedy_decoder_unit.sv]
// Timing: an item that does not end a sequence with kept characters has its
// result, if any, registered on the output at the accepting edge. An item that
// ends a sequence with kept characters starts a restoring division; S_DIV waits
// for the divider, S_EMIT registers the result once the output is free, and no
// item is taken before that. Otherwise one item per cycle while the output is free.
// Reset is asynchronous and clears all state; there is no clearing pass.
`default_nettype none

module ctc_greedy_decoder_unit
  import ctcgd_pkg::*;
#(
  parameter int unsigned CLASS_COUNT = 8192,
  parameter int unsigned MAX_STEPS   = 128
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int unsigned IdxW = $clog2(CLASS_COUNT);
  localparam logic [IdxW-1:0] LastClass = IdxW'(CLASS_COUNT - 1);
  localparam logic [CntW-1:0] CountCap =
    (MAX_STEPS < 255) ? CntW'(MAX_STEPS) : CountHwMax;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] class_cnt_q, class_cnt_d;
  logic [ProbW-1:0] best_val_q, best_val_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [IdxW-1:0] prev_idx_q, prev_idx_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_char_q, pend_char_d;
  logic [CharW-1:0] pend_idx_q, pend_idx_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            accept;
  logic            take;
  logic [ProbW-1:0] cur_val;
  logic [IdxW-1:0] cur_idx;
  logic            step_end;
  logic            seq_end;
  logic            kept;
  logic [SumW:0]   trial_sum;
  logic            add_score;
  logic [SumW-1:0] new_sum;
  logic [CntW-1:0] new_cnt;
  logic            out_free;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  ctcgd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Running argmax; the first class of a step always loads, ties keep the older index.
  assign take      = (class_cnt_q == '0) || (in_data_i.prob > best_val_q);
  assign cur_val   = take ? in_data_i.prob : best_val_q;
  assign cur_idx   = take ? class_cnt_q : best_idx_q;
  assign step_end  = in_data_i.last_in_step;
  assign seq_end   = step_end && in_data_i.last_in_sequence;
  assign kept      = (cur_idx != '0) && (cur_idx != prev_idx_q);
  assign trial_sum = {1'b0, sum_q} + {{(SumW + 1 - ProbW){1'b0}}, cur_val};
  assign add_score = kept && (cnt_q < CountCap) && (trial_sum <= {1'b0, SumMax});
  assign new_sum   = add_score ? trial_sum[SumW-1:0] : sum_q;
  assign new_cnt   = add_score ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    state_d     = state_q;
    class_cnt_d = class_cnt_q;
    best_val_d  = best_val_q;
    best_idx_d  = best_idx_q;
    prev_idx_d  = prev_idx_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    pend_char_d = pend_char_q;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, new_sum} + {{(DividendW - CntW + 1){1'b0}}, new_cnt[CntW-1:1]};
    div_req.divisor  = new_cnt;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          best_val_d  = cur_val;
          best_idx_d  = cur_idx;
          class_cnt_d = (class_cnt_q < LastClass) ? class_cnt_q + 1'b1 : class_cnt_q;
          if (step_end) begin
            class_cnt_d = '0;
            best_val_d  = '0;
            best_idx_d  = '0;
            prev_idx_d  = cur_idx;
            sum_d       = new_sum;
            cnt_d       = new_cnt;
            out_d.has_char        = kept;
            out_d.char_index      = kept ? CharW'(cur_idx) : '0;
            out_d.end_of_sequence = seq_end;
            out_d.mean_score      = '0;
            out_d.empty_sequence  = seq_end && (new_cnt == '0);
            if (seq_end) begin
              prev_idx_d = '0;
              sum_d      = '0;
              cnt_d      = '0;
              if (new_cnt == '0) begin
                out_valid_d = 1'b1;
              end else begin
                div_req.start = 1'b1;
                pend_char_d   = kept;
                pend_idx_d    = out_d.char_index;
                state_d       = S_DIV;
              end
            end else if (kept) begin
              out_valid_d = 1'b1;
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.has_char        = pend_char_q;
          out_d.char_index      = pend_idx_q;
          out_d.end_of_sequence = 1'b1;
          out_d.mean_score      = div_rsp.quotient;
          out_d.empty_sequence  = 1'b0;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      class_cnt_q <= '0;
      best_val_q  <= '0;
      best_idx_q  <= '0;
      prev_idx_q  <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      pend_char_q <= 1'b0;
      pend_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      class_cnt_q <= class_cnt_d;
      best_val_q  <= best_val_d;
      best_idx_q  <= best_idx_d;
      prev_idx_q  <= prev_idx_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      pend_char_q <= pend_char_d;
      pend_idx_q  <= pend_idx_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[src/ctcgd_checker.sv]
`default_nettype none
`include "ctc_greedy_decoder_unit_defines.svh"

module ctcgd_checker
  import ctcgd_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  logic in_stall;
  logic out_stall;
  logic out_content;
  logic blank_char;
  logic mid_result;
  logic score_clear;

  assign in_stall    = in_valid_i && !in_ready_o;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_content = out_data_o.has_char || out_data_o.end_of_sequence;
  assign blank_char  = out_data_o.has_char && (out_data_o.char_index == '0);
  assign mid_result  = out_valid_o && !out_data_o.end_of_sequence;
  assign score_clear = (out_data_o.mean_score == '0) && !out_data_o.empty_sequence;

  // A transaction on the output carries a character, a sequence end, or both.
  `CTCGD_ASSERT_NOW(a_result_has_content, out_valid_o, out_content, "empty result transaction")
  `CTCGD_ASSERT_NOW(a_char_not_blank, out_valid_o, !blank_char, "blank emitted as a character")
  `CTCGD_ASSERT_NOW(a_score_only_at_end, mid_result, score_clear, "score fields set early")
  `CTCGD_ASSERT_NEXT(a_stall_holds, out_stall, out_valid_o && $stable(out_data_o), "output changed")
  `CTCGD_ASSERT_NEXT(a_input_holds, in_stall, in_valid_i && $stable(in_data_i), "input changed")

endmodule

bind ctc_greedy_decoder_unit ctcgd_checker u_ctcgd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[tb/sv/ctc_greedy_decoder_unit_test.sv]
`timescale 1ns / 1ps

module ctc_greedy_decoder_unit_test;
  import ctcgd_pkg::*;

  localparam int unsigned ClassCount = 8192;
  localparam int unsigned MaxSteps   = 128;
  localparam int          CycleLimit = 1000000;
  localparam int          DrainCycles = 40;

  typedef enum int {
    PROB_NOISE,
    PROB_TIES,
    PROB_PEAK,
    PROB_FLAT
  } prob_shape_e;

  // Greedy decode predictor plus the queue of results it still waits for.
  class ctc_decode_scoreboard;
    logic [CharW-1:0] class_pos;
    logic [ProbW-1:0] best_prob;
    logic [CharW-1:0] best_class;
    logic [CharW-1:0] prev_class;
    logic [SumW-1:0]  kept_sum;
    logic [CntW-1:0]  kept_count;
    out_item_t        pending_decodes[$];
    int               mismatch_count;

    function new();
      class_pos      = '0;
      best_prob      = '0;
      best_class     = '0;
      prev_class     = '0;
      kept_sum       = '0;
      kept_count     = '0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction

    function void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        note_mismatch($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
      end
    endfunction

    function void take_probability(in_item_t item);
      logic                 step_end;
      logic                 seq_end;
      logic                 kept;
      logic [CharW-1:0]     arg;
      logic [SumW:0]        trial_sum;
      logic [DividendW-1:0] rounded;
      int unsigned          count_limit;
      out_item_t            want;
      count_limit = (MaxSteps < CountHwMax) ? MaxSteps : CountHwMax;
      step_end = item.last_in_step;
      seq_end  = step_end & item.last_in_sequence;
      if (class_pos == 0 || item.prob > best_prob) begin
        best_prob  = item.prob;
        best_class = class_pos;
      end
      // The class position sticks at the last index once a step runs long.
      if (class_pos < ClassCount - 1) begin
        class_pos++;
      end
      if (!step_end) begin
        return;
      end
      arg = best_class;
      kept = (arg != 0) && (arg != prev_class);
      trial_sum = kept_sum + best_prob;
      if (kept && kept_count < count_limit && trial_sum <= SumMax) begin
        kept_sum = trial_sum[SumW-1:0];
        kept_count++;
      end
      prev_class = arg;
      class_pos  = '0;
      best_prob  = '0;
      best_class = '0;
      if (!kept && !seq_end) begin
        return;
      end
      want = '0;
      want.has_char = kept;
      want.char_index = kept ? arg : '0;
      want.end_of_sequence = seq_end;
      if (seq_end) begin
        if (kept_count == 0) begin
          want.empty_sequence = 1'b1;
        end else begin
          rounded = (kept_sum + (kept_count >> 1)) / kept_count;
          want.mean_score = (rounded > 16'hFFFF) ? 16'hFFFF : rounded[ProbW-1:0];
        end
        prev_class = '0;
        kept_sum   = '0;
        kept_count = '0;
      end
      pending_decodes = {pending_decodes, want};
    endfunction

    function void check_decoded(out_item_t got);
      out_item_t want;
      if (pending_decodes.size() == 0) begin
        note_mismatch($sformatf("unexpected result transaction 0x%0h", got));
        return;
      end
      want = pending_decodes.pop_front();
      compare_field("has_char", 32'(want.has_char), 32'(got.has_char));
      compare_field("char_index", 32'(want.char_index), 32'(got.char_index));
      compare_field("end_of_sequence", 32'(want.end_of_sequence),
                    32'(got.end_of_sequence));
      compare_field("mean_score", 32'(want.mean_score), 32'(got.mean_score));
      compare_field("empty_sequence", 32'(want.empty_sequence),
                    32'(got.empty_sequence));
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  ctc_decode_scoreboard board;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_request  = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int cycle_count   = 0;

  ctc_greedy_decoder_unit #(
    .CLASS_COUNT(ClassCount),
    .MAX_STEPS  (MaxSteps)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("ctc_greedy_decoder_unit: mismatch");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_decoded(out_data_o);
      end
      if (hold_request != hold_taken) begin
        hold_left = hold_request;
        hold_taken = hold_request;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(logic [ProbW-1:0] prob, logic step_end, logic seq_end);
    in_item_t item;
    item.prob = prob;
    item.last_in_step = step_end;
    item.last_in_sequence = seq_end;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    board.take_probability(item);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One time step of n classes; flags on inner items are noise the block ignores.
  task automatic send_step(int n, int peak, prob_shape_e shape, logic seq_end);
    int               i;
    logic [ProbW-1:0] level;
    logic [ProbW-1:0] p;
    logic             last;
    level = ProbW'($urandom_range(65535));
    for (i = 0; i < n; i++) begin
      case (shape)
        PROB_NOISE: p = ProbW'($urandom_range(65535));
        PROB_TIES:  p = ProbW'($urandom_range(3));
        PROB_PEAK:  p = (i == peak) ? ProbW'($urandom_range(65535, 40000))
                                    : ProbW'($urandom_range(40000));
        default:    p = level;
      endcase
      last = (i == n - 1);
      send_item(p, last, last ? seq_end : ($urandom_range(4) == 0));
    end
  endtask

  task automatic send_random_sequence(int max_classes);
    int          steps;
    int          s;
    int          n;
    int          peak;
    int          prev_peak;
    prob_shape_e shape;
    steps = $urandom_range(8, 1);
    prev_peak = 0;
    for (s = 0; s < steps; s++) begin
      n = $urandom_range(max_classes, 1);
      shape = prob_shape_e'($urandom_range(3));
      // Repeating the previous peak exercises the duplicate-collapse rule.
      if ($urandom_range(9) < 4 && prev_peak < n) begin
        peak = prev_peak;
      end else begin
        peak = $urandom_range(n - 1);
      end
      send_step(n, peak, shape, s == steps - 1);
      prev_peak = peak;
    end
  endtask

  initial begin
    int phase;
    int target;
    int k;
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ties, repeats after blank, ignored sequence flag, empty sequence.
    send_item(16'h0000, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0005, 1'b0, 1'b1);
    send_item(16'h0005, 1'b0, 1'b0);
    send_item(16'h0005, 1'b1, 1'b0);
    send_item(16'h0000, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0000, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0001, 1'b0, 1'b0);
    send_item(16'h0009, 1'b0, 1'b0);
    send_item(16'h0009, 1'b1, 1'b1);
    send_item(16'hFFFF, 1'b1, 1'b1);
    send_item(16'h0000, 1'b0, 1'b0);
    send_item(16'h0000, 1'b0, 1'b0);
    send_item(16'h0001, 1'b1, 1'b0);
    send_item(16'h7FFF, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b0, 1'b0);
    send_item(16'h0000, 1'b1, 1'b1);
    wait_drained();

    // More kept characters than the count can hold, offered while the
    // receiver holds off for a long stretch.
    hold_request = 400;
    for (k = 0; k < MaxSteps + 2; k++) begin
      send_step(3, (k % 2) + 1, PROB_PEAK, k == MaxSteps + 1);
    end
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      target = items_sent + 40;
      while (items_sent < target) begin
        send_random_sequence(($urandom_range(7) == 0) ? 40 : 10);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("ctc_greedy_decoder_unit: match");
    end else begin
      $display("ctc_greedy_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/ctcgd_pkg.sv
src/ctcgd_divider.sv
src/ctc_greedy_decoder_unit.sv
src/ctcgd_checker.sv
tb/sv/ctc_greedy_decoder_unit_test.sv
